@@ sv/xfpr_pkg.sv @@
// ----------------------------------------------------------------------------
// xfpr_pkg: shared types and constants of the framed packet receiver
// Frame delimiter bytes, payload limit, field widths and the parser phases.
// ----------------------------------------------------------------------------
package xfpr_pkg;

	localparam int BYTE_W      = 8;
	localparam int MAX_PAYLOAD = 64;
	localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);

	// Frame delimiters
	localparam logic [BYTE_W-1:0] SOF_CFG = 8'h53;
	localparam logic [BYTE_W-1:0] EOF_CFG = 8'h54;
	localparam logic [BYTE_W-1:0] SOF_DAT = 8'h57;
	localparam logic [BYTE_W-1:0] EOF_DAT = 8'h58;

	// Parser and emitter phases
	typedef enum logic [3:0] {
		PH_HUNT,
		PH_CMD,
		PH_CODE,
		PH_LEN,
		PH_DATA,
		PH_SUM,
		PH_END,
		PH_EMIT_RD,
		PH_EMIT_OUT
	} phase_t;

endpackage

@@ sv/xfpr_in_if.sv @@
// ----------------------------------------------------------------------------
// xfpr_in_if: received byte channel
// Valid/ready channel carrying one serial byte per request.
// ----------------------------------------------------------------------------
interface xfpr_in_if
	import xfpr_pkg::*;
;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ sv/xfpr_out_if.sv @@
// ----------------------------------------------------------------------------
// xfpr_out_if: decoded frame channel
// Valid/ready channel carrying one payload byte of a frame plus its header.
// ----------------------------------------------------------------------------
interface xfpr_out_if
	import xfpr_pkg::*;
;
	logic              valid;
	logic              ready;
	logic              frame_kind;
	logic [BYTE_W-1:0] command;
	logic [BYTE_W-1:0] sub_code;
	logic [LEN_W-1:0]  payload_length;
	logic [BYTE_W-1:0] payload_byte;
	logic              last;

	modport source (output valid, output frame_kind, output command, output sub_code,
		output payload_length, output payload_byte, output last, input ready);
	modport sink   (input valid, input frame_kind, input command, input sub_code,
		input payload_length, input payload_byte, input last, output ready);
endinterface

@@ sv/xfpr_pbuf.sv @@
// ----------------------------------------------------------------------------
// xfpr_pbuf: payload buffer
// Single write port, single registered read port byte memory.
// ----------------------------------------------------------------------------
module xfpr_pbuf
	import xfpr_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [AW-1:0]     wr_addr,
	input  logic [BYTE_W-1:0] wr_data,
	input  logic [AW-1:0]     rd_addr,
	output logic [BYTE_W-1:0] rd_data
);

	logic [BYTE_W-1:0] mem [DEPTH];
	logic [BYTE_W-1:0] rd_data_q;

	// Store payload bytes as they arrive
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Register the read data
	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

@@ sv/xor_framed_packet_receiver.sv @@
// ----------------------------------------------------------------------------
// Timing: input is accepted in every parsing phase; after a good frame's end byte
//   each payload byte passes through PH_EMIT_RD (buffer read) and PH_EMIT_OUT
//   (output load, which waits for a free output register); zero length skips
//   PH_EMIT_RD. Input is blocked until the whole payload has been replayed.
// Reset: control state returns to hunting at once; the buffer is not cleared.
// ----------------------------------------------------------------------------
// xor_framed_packet_receiver: start/length/XOR/end framed packet receiver
// Hunts for a start byte, collects header and payload with a running XOR,
// checks checksum and end byte, then replays the payload from the buffer.
// ----------------------------------------------------------------------------
module xor_framed_packet_receiver
	import xfpr_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	xfpr_in_if.sink   rx,
	xfpr_out_if.source frm
);

	localparam int LW = $clog2(MAX_PAYLOAD + 1);
	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	phase_t            state_q, state_d;
	logic              kind_q;
	logic [BYTE_W-1:0] cmd_q;
	logic [BYTE_W-1:0] code_q;
	logic [LW-1:0]     len_q;
	logic [LW-1:0]     cnt_q;
	logic [BYTE_W-1:0] xor_q;

	logic              ov_q;
	logic              o_kind_q;
	logic [BYTE_W-1:0] o_cmd_q;
	logic [BYTE_W-1:0] o_code_q;
	logic [LEN_W-1:0]  o_len_q;
	logic [BYTE_W-1:0] o_byte_q;
	logic              o_last_q;

	logic              rx_fire;
	logic              out_free;
	logic              out_load;
	logic              len_bad;
	logic              end_ok;
	logic [LW-1:0]     cnt_inc;
	logic              emit_last;
	logic              wr_en;
	logic [BYTE_W-1:0] rd_data;

	assign rx.ready  = (state_q != PH_EMIT_RD) && (state_q != PH_EMIT_OUT);
	assign rx_fire   = rx.valid && rx.ready;
	assign out_free  = !ov_q || frm.ready;
	assign out_load  = (state_q == PH_EMIT_OUT) && out_free;
	assign len_bad   = {1'b0, rx.rx_byte} > 9'(MAX_PAYLOAD);
	assign end_ok    = rx.rx_byte == (kind_q ? EOF_DAT : EOF_CFG);
	assign cnt_inc   = cnt_q + 1'b1;
	assign emit_last = (len_q == '0) || (cnt_inc == len_q);
	assign wr_en     = rx_fire && (state_q == PH_DATA);

	xfpr_pbuf #(
		.DEPTH (MAX_PAYLOAD),
		.AW    (AW)
	) u_pbuf (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (cnt_q[AW-1:0]),
		.wr_data (rx.rx_byte),
		.rd_addr (cnt_q[AW-1:0]),
		.rd_data (rd_data)
	);

	// Phase register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= PH_HUNT;
		end else begin
			state_q <= state_d;
		end
	end

	// Next phase
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			PH_HUNT: begin
				if (rx_fire && (rx.rx_byte == SOF_CFG || rx.rx_byte == SOF_DAT)) begin
					state_d = PH_CMD;
				end
			end
			PH_CMD: begin
				if (rx_fire) state_d = PH_CODE;
			end
			PH_CODE: begin
				if (rx_fire) state_d = PH_LEN;
			end
			PH_LEN: begin
				if (rx_fire) begin
					if (len_bad) state_d = PH_HUNT;
					else if (rx.rx_byte == '0) state_d = PH_SUM;
					else state_d = PH_DATA;
				end
			end
			PH_DATA: begin
				if (rx_fire && cnt_inc == len_q) state_d = PH_SUM;
			end
			PH_SUM: begin
				if (rx_fire) state_d = (xor_q == rx.rx_byte) ? PH_END : PH_HUNT;
			end
			PH_END: begin
				if (rx_fire) begin
					if (!end_ok) state_d = PH_HUNT;
					else if (len_q == '0) state_d = PH_EMIT_OUT;
					else state_d = PH_EMIT_RD;
				end
			end
			PH_EMIT_RD: begin
				state_d = PH_EMIT_OUT;
			end
			PH_EMIT_OUT: begin
				if (out_load) state_d = emit_last ? PH_HUNT : PH_EMIT_RD;
			end
			default: begin
				state_d = PH_HUNT;
			end
		endcase
	end

	// Header fields, byte counter and running checksum
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= 1'b0;
			cmd_q  <= '0;
			code_q <= '0;
			len_q  <= '0;
			cnt_q  <= '0;
			xor_q  <= '0;
		end else begin
			unique case (state_q)
				PH_HUNT: begin
					if (rx_fire) kind_q <= (rx.rx_byte == SOF_DAT);
				end
				PH_CMD: begin
					if (rx_fire) begin
						cmd_q <= rx.rx_byte;
						xor_q <= rx.rx_byte;
					end
				end
				PH_CODE: begin
					if (rx_fire) begin
						code_q <= rx.rx_byte;
						xor_q  <= xor_q ^ rx.rx_byte;
					end
				end
				PH_LEN: begin
					if (rx_fire) begin
						cnt_q <= '0;
						if (!len_bad) begin
							len_q <= LW'(rx.rx_byte);
							xor_q <= xor_q ^ rx.rx_byte;
						end
					end
				end
				PH_DATA: begin
					if (rx_fire) begin
						xor_q <= xor_q ^ rx.rx_byte;
						cnt_q <= cnt_inc;
					end
				end
				PH_END: begin
					// rewind the counter to replay the buffer
					if (rx_fire) cnt_q <= '0;
				end
				PH_EMIT_OUT: begin
					if (out_load) cnt_q <= cnt_inc;
				end
				default: begin
				end
			endcase
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (out_load) begin
			ov_q <= 1'b1;
		end else if (frm.ready) begin
			ov_q <= 1'b0;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (out_load) begin
			o_kind_q <= kind_q;
			o_cmd_q  <= cmd_q;
			o_code_q <= code_q;
			o_len_q  <= LEN_W'(len_q);
			o_byte_q <= (len_q == '0) ? '0 : rd_data;
			o_last_q <= emit_last;
		end
	end

	assign frm.valid          = ov_q;
	assign frm.frame_kind     = o_kind_q;
	assign frm.command        = o_cmd_q;
	assign frm.sub_code       = o_code_q;
	assign frm.payload_length = o_len_q;
	assign frm.payload_byte   = o_byte_q;
	assign frm.last           = o_last_q;

	// Counter stays inside the frame while collecting payload
	a_cnt_in_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == PH_DATA) |-> (cnt_q < len_q))
		else $error("payload counter ran past frame length");

	// Held length never exceeds the buffer depth
	a_len_fits: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(MAX_PAYLOAD))
		else $error("held length beyond buffer depth");

	// Replay starts only from a checked end byte
	a_emit_entry: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == PH_EMIT_RD || state_q == PH_EMIT_OUT) &&
		 $past(state_q) != PH_EMIT_RD && $past(state_q) != PH_EMIT_OUT)
		|-> $past(state_q) == PH_END)
		else $error("payload replay entered without end byte");

endmodule
